// ===== sv/bba_pkg.sv =====
package bba_pkg;

  // Pool geometry
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int CNT_W      = 7;
  localparam int SPAN_W     = SIZE_W + CNT_W;
  localparam int K_W        = $clog2(IDX_W);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDR   = 2'd0,
    CFG_BLOCK_SIZE  = 2'd1,
    CFG_BLOCK_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STAT_DONE         = 2'd0,
    STAT_FULL         = 2'd1,
    STAT_OUTSIDE      = 2'd2,
    STAT_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RANGE,
    ST_DIV,
    ST_CHECK,
    ST_DONE
  } state_e;

  // Live configuration
  typedef struct packed {
    logic [ADDR_W-1:0] base_addr;
    logic [SIZE_W-1:0] block_size;
    logic [CNT_W-1:0]  block_count;
  } cfg_t;

  // Map update command
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
  } map_cmd_t;

  // Shared adder operands and result
  typedef struct packed {
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] y;
    logic              carry;
  } alu_rsp_t;

  // Finished result
  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] block_addr;
  } res_t;

endpackage

// ===== sv/bba_req_if.sv =====
interface bba_req_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [bba_pkg::ADDR_W-1:0] addr;

  modport source (output valid, output func, output addr, input ready);
  modport sink   (input valid, input func, input addr, output ready);
endinterface

// ===== sv/bba_rsp_if.sv =====
interface bba_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [bba_pkg::ADDR_W-1:0] block_addr;

  modport source (output valid, output status, output block_addr, input ready);
  modport sink   (input valid, input status, input block_addr, output ready);
endinterface

// ===== sv/bba_cfg_if.sv =====
interface bba_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bba_pkg::CFG_IDX_W-1:0]  index;
  logic [bba_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/bba_bitmap.sv =====
module bba_bitmap (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bba_pkg::map_cmd_t              cmd_i,
  input  logic [bba_pkg::IDX_W-1:0]      rd_idx_i,
  output logic                           rd_bit_o
);

  logic [bba_pkg::MAX_BLOCKS-1:0] used_q;
  logic [bba_pkg::MAX_BLOCKS-1:0] used_d;

  // One used bit per block, all free after reset
  always_comb begin
    used_d = used_q;
    if (cmd_i.set) begin
      used_d[cmd_i.idx] = 1'b1;
    end else if (cmd_i.clr) begin
      used_d[cmd_i.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  assign rd_bit_o = used_q[rd_idx_i];

endmodule

// ===== sv/bba_alu.sv =====
module bba_alu (
  input  bba_pkg::alu_req_t req_i,
  output bba_pkg::alu_rsp_t rsp_o
);

  logic [bba_pkg::ADDR_W:0] sum;
  logic [bba_pkg::ADDR_W-1:0] b_eff;

  // Add, or subtract as a + ~b + 1; carry set means a >= b on subtract
  assign b_eff = req_i.sub ? ~req_i.b : req_i.b;
  assign sum   = {1'b0, req_i.a} + {1'b0, b_eff} +
                 {{bba_pkg::ADDR_W{1'b0}}, req_i.sub};

  assign rsp_o.y     = sum[bba_pkg::ADDR_W-1:0];
  assign rsp_o.carry = sum[bba_pkg::ADDR_W];

endmodule

// ===== sv/bba_ctrl.sv =====
module bba_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bba_pkg::cfg_t               cfg_i,
  input  logic                        req_valid_i,
  input  logic                        req_func_i,
  input  logic [bba_pkg::ADDR_W-1:0]  req_addr_i,
  output logic                        req_ready_o,
  output bba_pkg::alu_req_t           alu_req_o,
  input  bba_pkg::alu_rsp_t           alu_rsp_i,
  output bba_pkg::map_cmd_t           map_cmd_o,
  output logic [bba_pkg::IDX_W-1:0]   map_idx_o,
  input  logic                        map_bit_i,
  output logic                        res_valid_o,
  output bba_pkg::res_t               res_o,
  input  logic                        out_free_i
);

  bba_pkg::state_e               state_q, state_d;
  logic [bba_pkg::ADDR_W-1:0]    rem_q, rem_d;
  logic [bba_pkg::SPAN_W-1:0]    span_q, span_d;
  logic [bba_pkg::CNT_W-1:0]     idx_q, idx_d;
  logic [bba_pkg::K_W-1:0]       k_q, k_d;
  bba_pkg::res_t                 res_q, res_d;

  logic [bba_pkg::CNT_W-1:0]     live_n;
  logic [bba_pkg::ADDR_W-1:0]    size_ext;
  logic                          accept;
  logic                          scan_end;

  // Blocks visible to requests
  assign live_n = (cfg_i.block_count > bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS)) ?
                  bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS) : cfg_i.block_count;
  assign size_ext = bba_pkg::ADDR_W'(cfg_i.block_size);
  assign accept   = req_valid_i && (state_q == bba_pkg::ST_IDLE);
  assign scan_end = (idx_q >= live_n);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bba_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (req_func_i == bba_pkg::FUNC_FREE) ? bba_pkg::ST_RANGE
                                                       : bba_pkg::ST_SCAN;
        end
      end
      bba_pkg::ST_SCAN: begin
        if (scan_end || !map_bit_i) begin
          state_d = bba_pkg::ST_DONE;
        end
      end
      bba_pkg::ST_RANGE: begin
        state_d = alu_rsp_i.carry ? bba_pkg::ST_DONE : bba_pkg::ST_DIV;
      end
      bba_pkg::ST_DIV: begin
        if (k_q == '0) begin
          state_d = bba_pkg::ST_CHECK;
        end
      end
      bba_pkg::ST_CHECK: state_d = bba_pkg::ST_DONE;
      bba_pkg::ST_DONE: begin
        if (out_free_i) begin
          state_d = bba_pkg::ST_IDLE;
        end
      end
      default: state_d = bba_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    rem_d         = rem_q;
    span_d        = span_q;
    idx_d         = idx_q;
    k_d           = k_q;
    res_d         = res_q;
    alu_req_o.a   = rem_q;
    alu_req_o.b   = size_ext;
    alu_req_o.sub = 1'b1;
    map_cmd_o.set = 1'b0;
    map_cmd_o.clr = 1'b0;
    map_cmd_o.idx = idx_q[bba_pkg::IDX_W-1:0];
    map_idx_o     = idx_q[bba_pkg::IDX_W-1:0];
    case (state_q)
      bba_pkg::ST_IDLE: begin
        // offset = addr - base; span = size * live count
        alu_req_o.a = req_addr_i;
        alu_req_o.b = cfg_i.base_addr;
        if (accept) begin
          idx_d  = '0;
          span_d = bba_pkg::SPAN_W'(cfg_i.block_size) * bba_pkg::SPAN_W'(live_n);
          rem_d  = (req_func_i == bba_pkg::FUNC_FREE) ? alu_rsp_i.y : cfg_i.base_addr;
        end
      end
      bba_pkg::ST_SCAN: begin
        // Walk the map one block a cycle, address accumulates by size
        alu_req_o.sub = 1'b0;
        if (scan_end) begin
          res_d.status     = bba_pkg::STAT_FULL;
          res_d.block_addr = '0;
        end else if (!map_bit_i) begin
          map_cmd_o.set    = 1'b1;
          res_d.status     = bba_pkg::STAT_DONE;
          res_d.block_addr = rem_q;
        end else begin
          idx_d = idx_q + 1'b1;
          rem_d = alu_rsp_i.y;
        end
      end
      bba_pkg::ST_RANGE: begin
        // Outside when offset >= span (covers zero size and zero count)
        alu_req_o.b = bba_pkg::ADDR_W'(span_q);
        res_d.status     = bba_pkg::STAT_OUTSIDE;
        res_d.block_addr = '0;
        idx_d = '0;
        k_d   = bba_pkg::K_W'(bba_pkg::IDX_W - 1);
      end
      bba_pkg::ST_DIV: begin
        // Restoring division, one quotient bit a cycle, MSB first
        alu_req_o.b = size_ext << k_q;
        if (alu_rsp_i.carry) begin
          rem_d      = alu_rsp_i.y;
          idx_d[k_q] = 1'b1;
        end
        if (k_q != '0) begin
          k_d = k_q - 1'b1;
        end
      end
      bba_pkg::ST_CHECK: begin
        res_d.block_addr = '0;
        if (map_bit_i) begin
          map_cmd_o.clr = 1'b1;
          res_d.status  = bba_pkg::STAT_DONE;
        end else begin
          res_d.status  = bba_pkg::STAT_ALREADY_FREE;
        end
      end
      bba_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    span_q <= span_d;
    idx_q  <= idx_d;
    k_q    <= k_d;
    res_q  <= res_d;
  end

  assign req_ready_o = (state_q == bba_pkg::ST_IDLE);
  assign res_valid_o = (state_q == bba_pkg::ST_DONE);
  assign res_o       = res_q;

endmodule

// ===== sv/bitmap_block_allocator.sv =====
// Fixed-size block allocator over a pool of up to 64 equal blocks.
// Channels: req_i (func, addr) takes one request per transaction; rsp_o
// returns exactly one result (status, block_addr) per request, in order;
// cfg_i writes base_addr (index 0), block_size (1), block_count (2), and
// is always ready. Write configuration only while the block is idle.
// Allocate: the map is scanned from block 0 one block per cycle up to the
// first free block, which is granted, or up to the live count when the
// pool is full.
// Free: offset subtract at acceptance, range compare and six restoring-division
// steps on one shared 32-bit adder, then a map check; an address outside the
// pool ends the request after the range compare.
// req_i.ready is high only while no request is in flight; it rises as the
// result moves to rsp_o, so a new request is not taken before the last one
// is through.
// A new request may be taken while the previous result still waits in rsp_o.
// If the receiver stalls, the result holds in rsp_o and a finished
// request waits in the sequencer until the output register frees.
// Reset (asynchronous, rst_ni low) marks every block free and restores
// base 0, size 16, count 64.
module bitmap_block_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  bba_req_if.sink       req_i,
  bba_rsp_if.source     rsp_o,
  bba_cfg_if.sink       cfg_i
);

  bba_pkg::cfg_t      cfg_q;
  bba_pkg::alu_req_t  alu_req;
  bba_pkg::alu_rsp_t  alu_rsp;
  bba_pkg::map_cmd_t  map_cmd;
  logic [bba_pkg::IDX_W-1:0] map_idx;
  logic               map_bit;
  logic               res_valid;
  bba_pkg::res_t      res;
  logic               out_free;
  logic               out_valid_q;
  bba_pkg::res_t      out_q;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_addr   <= '0;
      cfg_q.block_size  <= bba_pkg::SIZE_W'(16);
      cfg_q.block_count <= bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS);
    end else if (cfg_i.valid) begin
      case (bba_pkg::cfg_idx_e'(cfg_i.index))
        bba_pkg::CFG_BASE_ADDR:   cfg_q.base_addr   <= cfg_i.data[bba_pkg::ADDR_W-1:0];
        bba_pkg::CFG_BLOCK_SIZE:  cfg_q.block_size  <= cfg_i.data[bba_pkg::SIZE_W-1:0];
        bba_pkg::CFG_BLOCK_COUNT: cfg_q.block_count <= cfg_i.data[bba_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (req_i.valid),
    .req_func_i  (req_i.func),
    .req_addr_i  (req_i.addr),
    .req_ready_o (req_i.ready),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .map_cmd_o   (map_cmd),
    .map_idx_o   (map_idx),
    .map_bit_i   (map_bit),
    .res_valid_o (res_valid),
    .res_o       (res),
    .out_free_i  (out_free)
  );

  bba_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  bba_bitmap u_bitmap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (map_cmd),
    .rd_idx_i (map_idx),
    .rd_bit_o (map_bit)
  );

  // Output register
  assign out_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.block_addr = out_q.block_addr;

  // Busy right after a request is taken
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready
  ) else $error("request accepted while previous one in flight");

  // Only a free block is ever granted
  a_set_only_free: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    map_cmd.set |-> (!map_bit && !map_cmd.clr)
  ) else $error("allocating a block that is already used");

  // A finished result reaches the output when the slot is free
  a_result_moves: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (res_valid && out_free) |=> (rsp_o.valid && !res_valid)
  ) else $error("finished result not moved to output");

endmodule
